FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define TPSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// signal holds in the cycle after the condition
`define TPSP_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

FILE: rtl/tpsp_pkg.sv
package tpsp_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned UNM_W   = 7;
  localparam int unsigned TOL_W   = 20;
  localparam int unsigned BOUND_W = TOL_W + 1;
  localparam int unsigned AY_W    = 22;
  localparam int unsigned K_W     = 31;
  localparam int unsigned PROD_W  = AY_W + K_W;
  localparam int unsigned FRAC_W  = 30;

  localparam logic [K_W-1:0]     SQRT3_Q30 = 31'd1859775393;
  localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
  localparam logic signed [33:0] TWO_Q30   = 34'sd2147483648;
  localparam logic [TOL_W-1:0]   TOL_RESET = 20'd4;

  localparam logic REG_SYMMETRY_MODE   = 1'b0;
  localparam logic REG_MATCH_TOLERANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_LATCH,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] tag;
  } probe_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] tag;
  } result_t;

endpackage

FILE: rtl/tpsp_ram.sv
module tpsp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tpsp_dist.sv
module tpsp_dist import tpsp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          flush_i,
  input  logic                          mode_i,
  input  logic [TOL_W-1:0]              tol_i,
  input  logic signed [COORD_WIDTH-1:0] pi_x_i,
  input  logic signed [COORD_WIDTH-1:0] pi_y_i,
  input  logic signed [COORD_WIDTH-1:0] pj_x_i,
  input  logic signed [COORD_WIDTH-1:0] pj_y_i,
  input  probe_t                        probe_i,
  output result_t                       res_o
);

  localparam int unsigned EW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int unsigned DW = EW + 4;
  localparam logic signed [DW-1:0] OneQ = DW'(ONE_Q30);
  localparam logic signed [DW-1:0] TwoQ = DW'(TWO_Q30);
  localparam logic [DW-1:0]        AyLimit = DW'(1) << AY_W;

  logic signed [DW-1:0] xi, yi, xj, yj;
  logic signed [DW-1:0] dx_d, dyb_d, dx_q, dyb_q;
  logic [DW-1:0]        adx, ady;
  logic [BOUND_W-1:0]   bound;
  probe_t               s1_d, s1_q, s2_d, s2_q, s3_d, s3_q;
  logic                 ok2_d, ok2_q, ok3_q;
  logic [AY_W-1:0]      ay_q;
  logic [PROD_W-1:0]    prod_d, prod_q;

  assign xi    = DW'(pi_x_i);
  assign yi    = DW'(pi_y_i);
  assign xj    = DW'(pj_x_i);
  assign yj    = DW'(pj_y_i);
  assign bound = {tol_i, 1'b0};

  // barycentric differences, units of 2^-30
  always_comb begin
    if (mode_i == 1'b0) begin
      dx_d  = (xi <<< 1) + yi + xj - yj + OneQ;
      dyb_d = yi + xj + yj + OneQ;
    end else begin
      dx_d  = (xi <<< 1) + yi + (xj <<< 1) + yj + TwoQ;
      dyb_d = yi - yj;
    end
  end

  assign adx    = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign ady    = dyb_q[DW-1] ? DW'(-dyb_q) : DW'(dyb_q);
  assign ok2_d  = (adx < DW'(bound)) && (ady < AyLimit);
  assign prod_d = PROD_W'(ay_q) * PROD_W'(SQRT3_Q30);

  always_comb begin
    s1_d       = probe_i;
    s1_d.valid = probe_i.valid && !flush_i;
    s2_d       = s1_q;
    s2_d.valid = s1_q.valid && !flush_i;
    s3_d       = s2_q;
    s3_d.valid = s2_q.valid && !flush_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dyb_q  <= dyb_d;
    ok2_q  <= ok2_d;
    ay_q   <= ady[AY_W-1:0];
    ok3_q  <= ok2_q;
    prod_q <= prod_d;
  end

  assign res_o.valid = s3_q.valid;
  assign res_o.tag   = s3_q.tag;
  assign res_o.hit   = ok3_q && (prod_q < PROD_W'({bound, {FRAC_W{1'b0}}}));

endmodule

FILE: rtl/triangle_point_symmetry_permutation.sv
// loading: one point per cycle, a last_point item starts the search
// search: per original point the FETCH and LATCH states read it, then one probe per cycle on the
//   coordinate memory read port, up to n probes, each through the read and distance pipeline
// output: each permutation entry is read from the table memory in EMIT_RD and loaded in
//   EMIT_LD, held while m_axis_tready is low; next set loads while the last entry waits
// reset: async, clears control, mode 0, tolerance 4; memories are not cleared
module triangle_point_symmetry_permutation import tpsp_pkg::*; #(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,  // coord_x, coord_y
  input  logic              s_axis_tlast,  // last_point
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,  // position, source_index, matched, unmatched_points
  output logic              m_axis_tlast,  // last_entry
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [TOL_W-1:0]  cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned EW    = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int unsigned CW    = COORD_WIDTH;

  state_e state_q, state_d;

  logic                mode_q;
  logic [TOL_W-1:0]    tol_q;
  logic [CNT_W-1:0]    count_q, count_d, n_q, n_d, n_m1, j_q, j_d, unm_q, unm_d;
  logic [AW-1:0]       i_q, i_d, ej_q, ej_d;
  logic [MAX_POINTS-1:0] written_q, written_d;
  logic signed [CW-1:0] pi_x_q, pi_y_q, pj_x, pj_y;
  probe_t              probe_q, probe_d;
  result_t             res;

  logic                acc_in, store_en, issue, hit, miss_end, done_i, last_i, out_load;
  logic [EW-1:0]       x_ext, y_ext;
  logic [2*CW-1:0]     coord_wdata, coord_rdata;
  logic [AW-1:0]       coord_raddr;
  logic [IDX_W-1:0]    perm_rdata;

  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    out_pos_q, out_src_q;
  logic                out_matched_q, out_last_q;
  logic [UNM_W-1:0]    out_unm_q;

  assign acc_in      = s_axis_tvalid && s_axis_tready;
  assign store_en    = acc_in && (count_q < CNT_W'(MAX_POINTS));
  assign x_ext       = EW'(s_axis_tdata[31:0]);
  assign y_ext       = EW'(s_axis_tdata[63:32]);
  assign coord_wdata = {y_ext[CW-1:0], x_ext[CW-1:0]};
  assign pj_x        = coord_rdata[CW-1:0];
  assign pj_y        = coord_rdata[2*CW-1:CW];
  assign n_m1        = n_q - CNT_W'(1);
  assign hit         = res.valid && res.hit;
  assign miss_end    = res.valid && !res.hit && (res.tag == IDX_W'(n_m1[AW-1:0]));
  assign done_i      = (state_q == ST_SCAN) && (hit || miss_end);
  assign last_i      = (i_q == n_m1[AW-1:0]);

  tpsp_ram #(.WIDTH(2 * CW), .DEPTH(MAX_POINTS)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (coord_wdata),
    .raddr_i (coord_raddr),
    .rdata_o (coord_rdata)
  );

  tpsp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (done_i && hit),
    .waddr_i (res.tag[AW-1:0]),
    .wdata_i (IDX_W'(i_q)),
    .raddr_i (ej_q),
    .rdata_o (perm_rdata)
  );

  tpsp_dist #(.COORD_WIDTH(CW)) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (done_i),
    .mode_i  (mode_q),
    .tol_i   (tol_q),
    .pi_x_i  (pi_x_q),
    .pi_y_i  (pi_y_q),
    .pj_x_i  (pj_x),
    .pj_y_i  (pj_y),
    .probe_i (probe_q),
    .res_o   (res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:    if (acc_in && s_axis_tlast) state_d = ST_FETCH;
      ST_FETCH:   state_d = ST_LATCH;
      ST_LATCH:   state_d = ST_SCAN;
      ST_SCAN: begin
        if (done_i) state_d = last_i ? ST_EMIT_RD : ST_FETCH;
      end
      ST_EMIT_RD: state_d = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_load) state_d = (ej_q == n_m1[AW-1:0]) ? ST_LOAD : ST_EMIT_RD;
      end
      default:    state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_LOAD);
    issue         = (state_q == ST_SCAN) && (j_q < n_q) && !done_i;
    coord_raddr   = (state_q == ST_FETCH) ? i_q : j_q[AW-1:0];
    out_load      = (state_q == ST_EMIT_LD) && (!out_valid_q || m_axis_tready);
    probe_d.valid = issue;
    probe_d.tag   = IDX_W'(j_q[AW-1:0]);
    out_valid_d   = out_load ? 1'b1 : (out_valid_q && !m_axis_tready);

    count_d   = store_en ? count_q + CNT_W'(1) : count_q;
    n_d       = n_q;
    i_d       = i_q;
    j_d       = issue ? j_q + CNT_W'(1) : j_q;
    ej_d      = ej_q;
    unm_d     = unm_q;
    written_d = written_q;

    if (acc_in && s_axis_tlast) begin
      count_d   = '0;
      n_d       = count_q + CNT_W'(store_en);
      i_d       = '0;
      ej_d      = '0;
      unm_d     = '0;
      written_d = '0;
    end
    if (state_q == ST_LATCH) j_d = '0;
    if (done_i) begin
      i_d = i_q + AW'(1);
      if (hit) written_d[res.tag[AW-1:0]] = 1'b1;
      if (miss_end) unm_d = unm_q + CNT_W'(1);
    end
    if (out_load) ej_d = ej_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      mode_q      <= 1'b0;
      tol_q       <= TOL_RESET;
      count_q     <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ej_q        <= '0;
      unm_q       <= '0;
      written_q   <= '0;
      probe_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      ej_q        <= ej_d;
      unm_q       <= unm_d;
      written_q   <= written_d;
      probe_q     <= probe_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SYMMETRY_MODE:   mode_q <= cfg_wdata_i[0];
          REG_MATCH_TOLERANCE: tol_q  <= cfg_wdata_i;
          default:             mode_q <= mode_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LATCH) begin
      pi_x_q <= pj_x;
      pi_y_q <= pj_y;
    end
    if (out_load) begin
      out_pos_q     <= IDX_W'(ej_q);
      out_matched_q <= written_q[ej_q];
      out_src_q     <= written_q[ej_q] ? perm_rdata : '0;
      out_unm_q     <= UNM_W'(unm_q);
      out_last_q    <= (ej_q == n_m1[AW-1:0]);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_unm_q, out_matched_q, out_src_q, out_pos_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/tpsp_checker.sv
`include "assert_macros.svh"

module tpsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic stall;

  assign stall = m_axis_tvalid && !m_axis_tready;

  `TPSP_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, stall, {m_axis_tvalid, m_axis_tdata, m_axis_tlast}, "output item changed while stalled")
  `TPSP_ASSERT(a_unmatched_src, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tdata[12]) |-> (m_axis_tdata[11:6] == 6'd0), "unmatched position with nonzero source")
  `TPSP_ASSERT(a_unm_range, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[19:13] <= 7'd64), "unmatched count out of range")
  `TPSP_ASSERT(a_no_load_mid_run, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready, "input taken before the run was emitted")
  `TPSP_ASSERT(a_last_input_stops, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready, "input still ready after the last point")

endmodule

bind triangle_point_symmetry_permutation tpsp_checker u_tpsp_checker (.*);
